// File: sv/ckct_pkg.sv
`timescale 1ns / 1ps
package ckct_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TAG_WIDTH = 16;

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_INDEX  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key_char;
    logic [15:0] child_tag;
    logic [7:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  out_char;
    logic [15:0] out_tag;
    logic [4:0]  entry_count;
    logic        full_drop;
  } res_t;

  typedef struct packed {
    logic load;
    logic do_insert;
    logic do_index;
    logic do_nop;
    logic scan_init;
    logic scan_dec;
    logic emit_hit;
    logic emit_miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       scan_empty;
    logic       scan_hit;
  } dp_stat_t;

  // ascii upper case folds to lower case, other bytes unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r = ch + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: sv/ckct_ctrl.sv
`timescale 1ns / 1ps
module ckct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ckct_pkg::dp_stat_t  stat_i,
  output ckct_pkg::ctrl_cmd_t cmd_o,
  output logic                busy_o
);
  import ckct_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.req_type)
          REQ_INSERT: begin
            cmd_o.do_insert = 1'b1;
            state_d         = S_IDLE;
          end
          REQ_INDEX: begin
            cmd_o.do_index = 1'b1;
            state_d        = S_IDLE;
          end
          REQ_SEARCH: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
          default: begin
            cmd_o.do_nop = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // walk from newest entry down to slot zero
        if (stat_i.scan_empty) begin
          cmd_o.emit_miss = 1'b1;
          state_d         = S_IDLE;
        end else if (stat_i.scan_hit) begin
          cmd_o.emit_hit = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.scan_dec = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ckct_dp.sv
`timescale 1ns / 1ps
module ckct_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ckct_pkg::req_t      req_i,
  input  ckct_pkg::ctrl_cmd_t cmd_i,
  output ckct_pkg::dp_stat_t  stat_o,
  output ckct_pkg::res_t      res_o,
  output logic                done_o
);
  import ckct_pkg::*;

  logic [7:0]           char_mem [DEPTH];
  logic [TAG_WIDTH-1:0] tag_mem  [DEPTH];

  req_t             req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  res_t             res_q, res_d;
  logic             done_q, done_d;

  logic                 full;
  logic                 idx_hit;
  logic [CNT_W-1:0]     slot;
  logic [CNT_W-1:0]     ptr_m1;
  logic [ADDR_W-1:0]    rd_addr;
  logic [7:0]           rd_char;
  logic [TAG_WIDTH-1:0] rd_tag;
  logic                 do_write;

  assign full     = (count_q == CNT_W'(DEPTH));
  assign idx_hit  = (CMP_W'(req_q.entry_index) < CMP_W'(count_q));
  assign slot     = count_q - CNT_W'(1) - CNT_W'(req_q.entry_index);
  assign ptr_m1   = ptr_q - CNT_W'(1);
  assign rd_addr  = cmd_i.do_index ? slot[ADDR_W-1:0] : ptr_m1[ADDR_W-1:0];
  assign rd_char  = char_mem[rd_addr];
  assign rd_tag   = tag_mem[rd_addr];
  assign do_write = cmd_i.do_insert && !full;

  assign stat_o.req_type   = req_q.req_type;
  assign stat_o.scan_empty = (ptr_q == '0);
  assign stat_o.scan_hit   = (fold_case(rd_char) == fold_case(req_q.key_char));

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      char_mem[count_q[ADDR_W-1:0]] <= req_q.key_char;
      tag_mem[count_q[ADDR_W-1:0]]  <= TAG_WIDTH'(req_q.child_tag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    done_d  = 1'b0;
    res_d   = res_q;
    if (do_write) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.scan_init) begin
      ptr_d = count_q;
    end else if (cmd_i.scan_dec) begin
      ptr_d = ptr_m1;
    end
    if (cmd_i.do_insert || cmd_i.do_nop || cmd_i.emit_miss ||
        (cmd_i.do_index && !idx_hit)) begin
      done_d            = 1'b1;
      res_d             = '0;
      res_d.entry_count = 5'(count_d);
      res_d.full_drop   = cmd_i.do_insert && full;
    end else if (cmd_i.emit_hit || cmd_i.do_index) begin
      done_d            = 1'b1;
      res_d             = '0;
      res_d.found       = 1'b1;
      res_d.out_char    = rd_char;
      res_d.out_tag     = 16'(rd_tag);
      res_d.entry_count = 5'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// File: sv/char_keyed_child_table.sv
`timescale 1ns / 1ps
// channel   handshake          payload
// request   start_i / busy_o   req_i   (req_type, key_char, child_tag, entry_index)
// result    done_o strobe      res_o   (found, out_char, out_tag, entry_count, full_drop)
//
// a word is taken when start_i is high and busy_o low; busy_o then stays high
// insert, index read and unused codes: result registered from the execute state
// search: held entries are read one at a time, newest first, through the single
// read port of the entry store, until a case-folded key match or none is left
// reset clears the fill count and control, the entry store needs no clearing
// done_o is high for a single cycle and res_o holds until the next result; the receiver cannot stall it
module char_keyed_child_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ckct_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output ckct_pkg::res_t res_o
);
  import ckct_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ckct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ckct_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o),
    .done_o (done_o)
  );

endmodule
